// ===== hw/rtl/tdpt_pkg.sv =====
// shared types, constants and microcode table for the trial-division prime test
package tdpt_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // microprogram step addresses, falling through from the last step wraps to idle
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SMALL = 3'd1,
    ST_BOUND = 3'd2,
    ST_DIVST = 3'd3,
    ST_DIVWT = 3'd4,
    ST_TEST  = 3'd5,
    ST_NEXT  = 3'd6,
    ST_EMIT  = 3'd7
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_NO_INPUT = 3'd2,
    CND_NOT_CAND = 3'd3,
    CND_SQ_GT_N  = 3'd4,
    CND_DIV_BUSY = 3'd5,
    CND_REM_ZERO = 3'd6,
    CND_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  take_in;       // ready for an input transaction
    logic  load;          // on fall-through: capture value, d=2, sq=4
    logic  div_start;     // start remainder n % d
    logic  advance;       // d+1, sq+2d+1
    logic  prime_on_jump; // verdict prime when jump taken
    logic  emit;          // on fall-through: write result register
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic not_cand;
    logic sq_gt_n;
    logic div_busy;
    logic rem_zero;
    logic out_busy;
  } status_t;

  function automatic ctrl_t microcode(input step_t step);
    ctrl_t c;
    c = '{cond: CND_NEVER, target: ST_IDLE, take_in: 1'b0, load: 1'b0,
          div_start: 1'b0, advance: 1'b0, prime_on_jump: 1'b0, emit: 1'b0};
    case (step)
      ST_IDLE: begin
        c.cond = CND_NO_INPUT; c.target = ST_IDLE; c.take_in = 1'b1; c.load = 1'b1;
      end
      ST_SMALL: begin
        c.cond = CND_NOT_CAND; c.target = ST_EMIT;
      end
      ST_BOUND: begin
        c.cond = CND_SQ_GT_N; c.target = ST_EMIT; c.prime_on_jump = 1'b1;
      end
      ST_DIVST: begin
        c.div_start = 1'b1;
      end
      ST_DIVWT: begin
        c.cond = CND_DIV_BUSY; c.target = ST_DIVWT;
      end
      ST_TEST: begin
        c.cond = CND_REM_ZERO; c.target = ST_EMIT;
      end
      ST_NEXT: begin
        c.cond = CND_ALWAYS; c.target = ST_BOUND; c.advance = 1'b1;
      end
      ST_EMIT: begin
        c.cond = CND_OUT_BUSY; c.target = ST_EMIT; c.emit = 1'b1;
      end
      default: begin
        c.cond = CND_ALWAYS; c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/tdpt_seq.sv =====
// microcode sequencer: step counter, control store lookup and jump logic
module tdpt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  tdpt_pkg::status_t status,
  output tdpt_pkg::ctrl_t   ctrl,
  output logic              taken
);

  tdpt_pkg::step_t pc_r, pc_nxt;

  always_comb begin
    ctrl = tdpt_pkg::microcode(pc_r);
  end

  always_comb begin
    case (ctrl.cond)
      tdpt_pkg::CND_NEVER:    taken = 1'b0;
      tdpt_pkg::CND_ALWAYS:   taken = 1'b1;
      tdpt_pkg::CND_NO_INPUT: taken = status.no_input;
      tdpt_pkg::CND_NOT_CAND: taken = status.not_cand;
      tdpt_pkg::CND_SQ_GT_N:  taken = status.sq_gt_n;
      tdpt_pkg::CND_DIV_BUSY: taken = status.div_busy;
      tdpt_pkg::CND_REM_ZERO: taken = status.rem_zero;
      tdpt_pkg::CND_OUT_BUSY: taken = status.out_busy;
      default:                taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = tdpt_pkg::step_t'(pc_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tdpt_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hw/rtl/tdpt_div.sv =====
// radix-2 restoring remainder unit, one quotient bit per cycle
module tdpt_div #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   rem_zero
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  assign busy     = (cnt_r != '0);
  assign rem_zero = (rem_r == '0);
  assign trial    = {rem_r, sh_r[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      sh_nxt  = dividend;
      cnt_nxt = CW'(VALUE_WIDTH);
    end else if (busy) begin
      sh_nxt  = {sh_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      // remainder stays below divisor, so the top trial bit drops safely
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
      end else begin
        rem_nxt = trial[VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

endmodule

// ===== hw/rtl/tdpt_dp.sv =====
// datapath: value, trial divisor, running square, verdict and result register
module tdpt_dp #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tdpt_pkg::ctrl_t        ctrl,
  input  logic                   taken,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   out_ready,
  input  logic                   div_busy,
  input  logic                   div_rem_zero,
  output logic [VALUE_WIDTH-1:0] n_val,
  output logic [VALUE_WIDTH-1:0] d_val,
  output tdpt_pkg::status_t      status,
  output logic                   out_valid,
  output logic                   out_is_prime
);

  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH:0]   sq_r, sq_nxt;   // d*d, kept by increments
  logic                   verdict_r, verdict_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic                   emit_now;

  assign n_val        = n_r;
  assign d_val        = d_r;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;
  assign emit_now     = ctrl.emit && !taken;

  always_comb begin
    status.no_input = !in_valid;
    status.not_cand = n_r[VALUE_WIDTH-1] || (n_r < VALUE_WIDTH'(2));
    status.sq_gt_n  = (sq_r > {1'b0, n_r});
    status.div_busy = div_busy;
    status.rem_zero = div_rem_zero;
    status.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    n_nxt       = n_r;
    d_nxt       = d_r;
    sq_nxt      = sq_r;
    verdict_nxt = verdict_r;
    if (ctrl.load && !taken) begin
      n_nxt       = in_value;
      d_nxt       = VALUE_WIDTH'(2);
      sq_nxt      = (VALUE_WIDTH + 1)'(4);
      verdict_nxt = 1'b0;
    end
    if (ctrl.advance) begin
      d_nxt  = d_r + VALUE_WIDTH'(1);
      sq_nxt = sq_r + {d_r, 1'b1};
    end
    if (ctrl.prime_on_jump && taken) begin
      verdict_nxt = 1'b1;
    end
  end

  always_comb begin
    out_prime_nxt = out_prime_r;
    if (emit_now) begin
      out_valid_nxt = 1'b1;
      out_prime_nxt = verdict_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    verdict_r   <= verdict_nxt;
    out_prime_r <= out_prime_nxt;
  end

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// top level of the trial-division prime test: stream ports, sequencer, datapath, divider
// each divisor tried for an item takes one run of the shared radix-2 remainder unit,
// and these runs bound the time per item; the search stops once d*d exceeds n or d divides n
// throughput: one item at a time; the next transaction is taken once the result is
// written to the output register; reset (synchronous, rst_n low) returns to idle, no result
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata   // [0] is_prime, [7:1] zero
);

  tdpt_pkg::ctrl_t        ctrl;
  tdpt_pkg::status_t      status;
  logic                   taken;
  logic [VALUE_WIDTH-1:0] n_val;
  logic [VALUE_WIDTH-1:0] d_val;
  logic                   div_busy;
  logic                   div_rem_zero;
  logic                   is_prime;

  // ready only in the idle step of the microprogram
  assign in_tready = ctrl.take_in;
  assign out_tdata = {7'd0, is_prime};

  // control store and step counter
  tdpt_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .taken  (taken)
  );

  // value, divisor, square bound and output register
  tdpt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .taken        (taken),
    .in_valid     (in_tvalid),
    .in_value     (in_tdata[VALUE_WIDTH-1:0]),
    .out_ready    (out_tready),
    .div_busy     (div_busy),
    .div_rem_zero (div_rem_zero),
    .n_val        (n_val),
    .d_val        (d_val),
    .status       (status),
    .out_valid    (out_tvalid),
    .out_is_prime (is_prime)
  );

  // shared remainder unit for n % d
  tdpt_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (n_val),
    .divisor  (d_val),
    .busy     (div_busy),
    .rem_zero (div_rem_zero)
  );

endmodule
